// ----- rtl/core/rtrs_pkg.sv -----
// Shared types and constants for the remote trip relay sequencer.
`default_nettype none

package rtrs_pkg;

    localparam int NUM_RELAYS_DEF = 8;
    localparam int TABLE_SLOTS    = 8;
    localparam int SLOT_W         = 3;
    localparam int MAP_W          = 8;
    localparam int PHASE_W        = 3;
    localparam int TIMER_W        = 16;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SCAN  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ALARM   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PREP    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TRIPPED = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;

    localparam logic [TIMER_W-1:0] TRIP_SETTLE_SECONDS = 16'd120;
    localparam logic [TIMER_W-1:0] SECONDS_PER_MINUTE  = 16'd60;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  slot;
        logic [31:0] relay_oad;
        logic [7:0]  alarm_minutes;
        logic [15:0] hold_minutes;
        logic [3:0]  entry_count;
        logic        protect_on;
        logic [7:0]  hold_done_mask;
    } rtrs_item_t;

    typedef struct packed {
        logic [7:0] command_bits;
        logic [7:0] trip_bits;
        logic [7:0] alarm_bits;
        logic [7:0] event_bits;
    } rtrs_result_t;

    typedef struct packed {
        logic              tick;
        logic              write;
        logic              protect;
        logic              respond;
        logic              scan_begin;
        logic              search;
        logic              step;
        logic              finish;
        logic [SLOT_W-1:0] entry;
        logic [SLOT_W-1:0] relay;
    } rtrs_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/remote_trip_relay_sequencer_top.sv -----
// Top level of the remote trip relay sequencer.
// A word is taken when start is high and busy is low, and its single result word appears on
// result for one cycle with result_valid high; the receiver cannot stall and must take it then.
// Tick, write, protected scan and spare words never raise busy, and their result appears in the next cycle.
// A normal scan keeps busy high while the controller walks every relay and, for each, all
// eight command table slots one per cycle followed by a step state, and closes with a finish
// state; the result follows in the cycle after that.
`default_nettype none

module remote_trip_relay_sequencer_top
    import rtrs_pkg::*;
#(
    parameter int NUM_RELAYS = NUM_RELAYS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire rtrs_item_t item,
    output rtrs_result_t    result,
    output logic            result_valid
);

    rtrs_cmd_t cmd;

    rtrs_ctrl #(
        .NUM_RELAYS (NUM_RELAYS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (item.action),
        .protect_on (item.protect_on),
        .busy       (busy),
        .cmd        (cmd)
    );

    rtrs_datapath #(
        .NUM_RELAYS (NUM_RELAYS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

// ----- rtl/core/rtrs_ctrl.sv -----
// Controller that sequences each word and walks relays and table entries during a scan.
`default_nettype none

module rtrs_ctrl
    import rtrs_pkg::*;
#(
    parameter int NUM_RELAYS = NUM_RELAYS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] action,
    input  wire logic       protect_on,
    output logic            busy,
    output rtrs_cmd_t       cmd
);

    localparam int RIDX_W = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_STEP   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] entry_reg, entry_next;
    logic [RIDX_W-1:0] relay_reg, relay_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            entry_reg <= '0;
            relay_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            relay_reg <= relay_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        relay_next = relay_reg;
        cmd        = '0;
        cmd.entry  = entry_reg;
        cmd.relay  = SLOT_W'(relay_reg);
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    priority if (action == ACT_TICK)
                    begin
                        cmd.tick    = 1'b1;
                        cmd.respond = 1'b1;
                    end
                    else if (action == ACT_WRITE)
                    begin
                        cmd.write   = 1'b1;
                        cmd.respond = 1'b1;
                    end
                    else if (action == ACT_SCAN && protect_on)
                    begin
                        cmd.protect = 1'b1;
                        cmd.respond = 1'b1;
                    end
                    else if (action == ACT_SCAN)
                    begin
                        cmd.scan_begin = 1'b1;
                        entry_next     = '0;
                        relay_next     = '0;
                        state_next     = S_SEARCH;
                    end
                    else
                    begin
                        cmd.respond = 1'b1;
                    end
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                entry_next = entry_reg + 1'b1;
                if (entry_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                entry_next = '0;
                if (relay_reg == RIDX_W'(NUM_RELAYS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    relay_next = relay_reg + 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/rtrs_datapath.sv -----
// Datapath holding the command table, relay phases, delay timers and status maps.
`default_nettype none

module rtrs_datapath
    import rtrs_pkg::*;
#(
    parameter int NUM_RELAYS = NUM_RELAYS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rtrs_item_t item,
    input  wire rtrs_cmd_t  cmd,
    output rtrs_result_t    result,
    output logic            result_valid
);

    localparam int RIDX_W = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;

    logic [31:0]        oad_reg   [TABLE_SLOTS];
    logic [7:0]         alarm_reg [TABLE_SLOTS];
    logic [15:0]        hold_reg  [TABLE_SLOTS];
    logic [3:0]         total_reg;
    logic [PHASE_W-1:0] phase_reg [NUM_RELAYS];
    logic [TIMER_W-1:0] timer_reg [NUM_RELAYS];
    logic [MAP_W-1:0]   command_map_reg, trip_map_reg, alarm_map_reg;

    logic [MAP_W-1:0]   cmd_acc_reg, event_acc_reg;
    logic [MAP_W-1:0]   hold_mask_reg;
    logic               found_reg;
    logic [7:0]         match_alarm_reg;
    logic               match_hold_nz_reg;
    rtrs_result_t       result_reg;
    logic               result_valid_reg;

    logic [RIDX_W-1:0]  ridx;
    logic [SLOT_W-1:0]  entry_pos;
    logic [SLOT_W-1:0]  relay_pos;
    logic               in_range;
    logic               is_match;
    logic [PHASE_W-1:0] cur_phase;
    logic [TIMER_W-1:0] cur_timer;
    logic [PHASE_W-1:0] step_phase;
    logic               step_load;
    logic [TIMER_W-1:0] step_timer;
    logic               step_event;
    logic [TIMER_W-1:0] alarm_secs;
    logic [MAP_W-1:0]   trp_bits, alm_bits;
    logic [3:0]         count_clamped;

    assign ridx       = cmd.relay[RIDX_W-1:0];
    assign entry_pos  = SLOT_W'(MAP_W - 1) - cmd.entry;
    assign relay_pos  = SLOT_W'(MAP_W - 1) - cmd.relay;
    assign in_range   = {1'b0, cmd.entry} < total_reg;
    assign is_match   = in_range && (oad_reg[cmd.entry][7:0] == 8'(cmd.relay) + 8'd1);
    assign cur_phase  = phase_reg[ridx];
    assign cur_timer  = timer_reg[ridx];
    assign alarm_secs = 16'(match_alarm_reg) * SECONDS_PER_MINUTE;
    assign count_clamped = (item.entry_count > 4'(NUM_RELAYS)) ? 4'(NUM_RELAYS)
                                                                : item.entry_count;

    always_comb
    begin
        step_phase = cur_phase;
        step_load  = 1'b0;
        step_timer = alarm_secs;
        step_event = 1'b0;
        if (!found_reg || (match_hold_nz_reg && hold_mask_reg[ridx]))
        begin
            step_phase = PH_IDLE;
        end
        else
        begin
            unique case (cur_phase)
                PH_IDLE:
                begin
                    step_phase = PH_ARMED;
                end
                PH_ARMED:
                begin
                    if (alarm_secs == '0)
                    begin
                        step_phase = PH_PREP;
                    end
                    else
                    begin
                        step_phase = PH_ALARM;
                        step_load  = 1'b1;
                    end
                end
                PH_ALARM:
                begin
                    if (cur_timer == '0)
                    begin
                        step_phase = PH_PREP;
                    end
                end
                PH_PREP:
                begin
                    step_phase = PH_TRIPPED;
                    step_load  = 1'b1;
                    step_timer = TRIP_SETTLE_SECONDS;
                end
                PH_TRIPPED:
                begin
                    if (cur_timer == '0)
                    begin
                        step_phase = PH_DONE;
                        step_event = 1'b1;
                    end
                end
                PH_DONE:
                begin
                    step_phase = PH_DONE;
                end
                default:
                begin
                    step_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        trp_bits = '0;
        alm_bits = '0;
        for (int i = 0; i < NUM_RELAYS; i++)
        begin
            trp_bits[MAP_W-1-i] = (phase_reg[i] >= PH_TRIPPED);
            alm_bits[MAP_W-1-i] = (phase_reg[i] == PH_ALARM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TABLE_SLOTS; s++)
            begin
                oad_reg[s]   <= '0;
                alarm_reg[s] <= '0;
                hold_reg[s]  <= '0;
            end
            for (int r = 0; r < NUM_RELAYS; r++)
            begin
                phase_reg[r] <= PH_IDLE;
                timer_reg[r] <= '0;
            end
            total_reg        <= '0;
            command_map_reg  <= '0;
            trip_map_reg     <= '0;
            alarm_map_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.respond || cmd.finish;
            if (cmd.write)
            begin
                oad_reg[item.slot]   <= item.relay_oad;
                alarm_reg[item.slot] <= item.alarm_minutes;
                hold_reg[item.slot]  <= item.hold_minutes;
                total_reg            <= count_clamped;
            end
            if (cmd.tick)
            begin
                for (int r = 0; r < NUM_RELAYS; r++)
                begin
                    if (timer_reg[r] != '0)
                    begin
                        timer_reg[r] <= timer_reg[r] - 1'b1;
                    end
                end
            end
            if (cmd.protect)
            begin
                for (int r = 0; r < NUM_RELAYS; r++)
                begin
                    phase_reg[r] <= PH_IDLE;
                end
            end
            if (cmd.step)
            begin
                phase_reg[ridx] <= step_phase;
                if (step_load)
                begin
                    timer_reg[ridx] <= step_timer;
                end
            end
            if (cmd.finish)
            begin
                command_map_reg <= cmd_acc_reg;
                trip_map_reg    <= trp_bits;
                alarm_map_reg   <= alm_bits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_begin)
        begin
            hold_mask_reg <= item.hold_done_mask;
            cmd_acc_reg   <= '0;
            event_acc_reg <= '0;
            found_reg     <= 1'b0;
        end
        if (cmd.search)
        begin
            if (in_range && oad_reg[cmd.entry] != '0)
            begin
                cmd_acc_reg[entry_pos] <= 1'b1;
            end
            if (!found_reg && is_match)
            begin
                found_reg         <= 1'b1;
                match_alarm_reg   <= alarm_reg[cmd.entry];
                match_hold_nz_reg <= (hold_reg[cmd.entry] != '0);
            end
        end
        if (cmd.step)
        begin
            found_reg <= 1'b0;
            if (step_event)
            begin
                event_acc_reg[relay_pos] <= 1'b1;
            end
        end
        if (cmd.respond)
        begin
            result_reg.command_bits <= command_map_reg;
            result_reg.trip_bits    <= trip_map_reg;
            result_reg.alarm_bits   <= alarm_map_reg;
            result_reg.event_bits   <= '0;
        end
        else if (cmd.finish)
        begin
            result_reg.command_bits <= cmd_acc_reg;
            result_reg.trip_bits    <= trp_bits;
            result_reg.alarm_bits   <= alm_bits;
            result_reg.event_bits   <= event_acc_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

// ----- verif/remote_trip_relay_sequencer_top_test.sv -----
// Self-checking testbench for the remote trip relay sequencer, with a relay phase predictor.
module remote_trip_relay_sequencer_top_test;
    import rtrs_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int RANDOM_WORDS   = 1450;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int PRINT_CAP      = 200;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    rtrs_item_t   item = '0;
    rtrs_result_t result;
    logic         result_valid;

    remote_trip_relay_sequencer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid)
    );

    always #10 clk = ~clk;

    rtrs_item_t   word_queue[$];
    rtrs_result_t status_due[$];

    logic [PHASE_W-1:0] phase_of[NUM_RELAYS_DEF];
    logic [TIMER_W-1:0] countdown[NUM_RELAYS_DEF];
    logic [31:0]        tbl_oad[TABLE_SLOTS];
    logic [7:0]         tbl_alarm[TABLE_SLOTS];
    logic [15:0]        tbl_hold[TABLE_SLOTS];
    int                 tbl_total = 0;
    logic [MAP_W-1:0]   command_map = '0;
    logic [MAP_W-1:0]   trip_map = '0;
    logic [MAP_W-1:0]   alarm_map = '0;

    int mismatches = 0;
    int results_seen = 0;
    int ticks_taken = 0;
    int scans_taken = 0;
    int writes_taken = 0;
    int spares_taken = 0;
    int done_events = 0;
    int alarm_scans = 0;

    int   gap_left = 0;
    int   calm_left = 0;
    logic start_n;
    int   quiet_cycles = 0;

    initial
    begin
        for (int i = 0; i < NUM_RELAYS_DEF; i++)
        begin
            phase_of[i]  = PH_IDLE;
            countdown[i] = '0;
        end
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            tbl_oad[s]   = '0;
            tbl_alarm[s] = '0;
            tbl_hold[s]  = '0;
        end
    end

    function automatic rtrs_result_t predict_status(rtrs_item_t w);
        rtrs_result_t     r;
        logic [MAP_W-1:0] events;
        logic [MAP_W-1:0] cmd;
        int               hit;
        events = '0;
        case (w.action)
            ACT_TICK:
            begin
                ticks_taken++;
                for (int i = 0; i < NUM_RELAYS_DEF; i++)
                    if (countdown[i] != 0)
                        countdown[i] = countdown[i] - 1'b1;
            end
            ACT_SCAN:
            begin
                scans_taken++;
                if (w.protect_on)
                begin
                    for (int i = 0; i < NUM_RELAYS_DEF; i++)
                        phase_of[i] = PH_IDLE;
                end
                else
                begin
                    cmd = '0;
                    for (int e = 0; e < tbl_total; e++)
                        if (tbl_oad[e] != 0)
                            cmd[7 - e] = 1'b1;
                    command_map = cmd;
                    for (int i = 0; i < NUM_RELAYS_DEF; i++)
                    begin
                        hit = -1;
                        for (int e = 0; e < tbl_total; e++)
                            if (hit < 0 && tbl_oad[e][7:0] == 8'(i + 1))
                                hit = e;
                        if (hit < 0 || (tbl_hold[hit] != 0 && w.hold_done_mask[i]))
                            phase_of[i] = PH_IDLE;
                        else
                        begin
                            case (phase_of[i])
                                PH_IDLE:
                                    phase_of[i] = PH_ARMED;
                                PH_ARMED:
                                    if (tbl_alarm[hit] == 0)
                                        phase_of[i] = PH_PREP;
                                    else
                                    begin
                                        countdown[i] = TIMER_W'(tbl_alarm[hit])
                                                       * SECONDS_PER_MINUTE;
                                        phase_of[i]  = PH_ALARM;
                                    end
                                PH_ALARM:
                                    if (countdown[i] == 0)
                                        phase_of[i] = PH_PREP;
                                PH_PREP:
                                begin
                                    countdown[i] = TRIP_SETTLE_SECONDS;
                                    phase_of[i]  = PH_TRIPPED;
                                end
                                PH_TRIPPED:
                                    if (countdown[i] == 0)
                                    begin
                                        phase_of[i]   = PH_DONE;
                                        events[7 - i] = 1'b1;
                                    end
                                PH_DONE:
                                    ;
                                default:
                                    phase_of[i] = PH_IDLE;
                            endcase
                        end
                    end
                    trip_map  = '0;
                    alarm_map = '0;
                    for (int i = 0; i < NUM_RELAYS_DEF; i++)
                    begin
                        trip_map[7 - i]  = (phase_of[i] >= PH_TRIPPED);
                        alarm_map[7 - i] = (phase_of[i] == PH_ALARM);
                    end
                    if (alarm_map != 0)
                        alarm_scans++;
                    if (events != 0)
                        done_events++;
                end
            end
            ACT_WRITE:
            begin
                writes_taken++;
                tbl_oad[w.slot]   = w.relay_oad;
                tbl_alarm[w.slot] = w.alarm_minutes;
                tbl_hold[w.slot]  = w.hold_minutes;
                tbl_total = (w.entry_count > NUM_RELAYS_DEF) ? NUM_RELAYS_DEF : w.entry_count;
            end
            default:
                spares_taken++;
        endcase
        r.command_bits = command_map;
        r.trip_bits    = trip_map;
        r.alarm_bits   = alarm_map;
        r.event_bits   = events;
        return r;
    endfunction

    function automatic rtrs_item_t make_word(logic [1:0] act);
        rtrs_item_t  w;
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        w = noise[$bits(rtrs_item_t)-1:0];
        w.action = act;
        return w;
    endfunction

    function automatic rtrs_item_t table_word(int s, logic [31:0] oad, logic [7:0] alarm,
                                              logic [15:0] hold, logic [3:0] cnt);
        rtrs_item_t w;
        w = make_word(ACT_WRITE);
        w.slot          = s[2:0];
        w.relay_oad     = oad;
        w.alarm_minutes = alarm;
        w.hold_minutes  = hold;
        w.entry_count   = cnt;
        return w;
    endfunction

    function automatic rtrs_item_t scan_word(logic prot, logic [7:0] mask);
        rtrs_item_t w;
        w = make_word(ACT_SCAN);
        w.protect_on     = prot;
        w.hold_done_mask = mask;
        return w;
    endfunction

    function automatic rtrs_item_t random_row(int s, logic [3:0] cnt);
        logic [31:0] oad;
        logic [7:0]  alarm;
        logic [15:0] hold;
        int          pick;
        oad  = $urandom();
        pick = $urandom_range(0, 19);
        if (pick == 0)
            oad = '0;
        else if (pick < 18)
            oad[7:0] = 8'($urandom_range(1, NUM_RELAYS_DEF));
        pick = $urandom_range(0, 9);
        if (pick < 6)
            alarm = 8'($urandom_range(0, 1));
        else if (pick < 8)
            alarm = 8'd2;
        else
            alarm = 8'($urandom_range(0, 255));
        hold = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        return table_word(s, oad, alarm, hold, cnt);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_bits(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %02h, expected %02h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            start_n = start;
            if (start && !busy)
            begin
                status_due.push_back(predict_status(item));
                start_n = 1'b0;
            end
            if (!start_n)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (word_queue.size() > 0)
                begin
                    item <= word_queue.pop_front();
                    start_n = 1'b1;
                    if (calm_left > 0)
                    begin
                        calm_left--;
                        gap_left = 0;
                    end
                    else
                    begin
                        gap_left = $urandom_range(0, 8);
                        if ($urandom_range(0, 24) == 0)
                            calm_left = $urandom_range(10, 40);
                    end
                end
            end
            start <= start_n;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (status_due.size() == 0)
                report_mismatch("result word with no expectation pending");
            else
            begin
                rtrs_result_t want;
                want = status_due.pop_front();
                check_bits("command_bits", result.command_bits, want.command_bits);
                check_bits("trip_bits", result.trip_bits, want.trip_bits);
                check_bits("alarm_bits", result.alarm_bits, want.alarm_bits);
                check_bits("event_bits", result.event_bits, want.event_bits);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d words queued and %0d results pending",
                     word_queue.size(), status_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int planned;
        int rows;
        int ticks;
        logic [3:0] cnt;

        word_queue.push_back(make_word(ACT_TICK));
        word_queue.push_back(scan_word(1'b0, 8'h00));
        word_queue.push_back(make_word(ACT_SPARE));
        word_queue.push_back(table_word(0, 32'h0000_0001, 8'h00, 16'h0000, 4'd15));
        word_queue.push_back(table_word(7, 32'hFFFF_FF08, 8'hFF, 16'hFFFF, 4'd8));
        word_queue.push_back(table_word(1, 32'h0000_0000, 8'h01, 16'h0000, 4'd8));
        word_queue.push_back(table_word(2, 32'h1234_5603, 8'h01, 16'h0005, 4'd8));
        word_queue.push_back(table_word(3, 32'hABCD_EF01, 8'h02, 16'h0000, 4'd8));
        word_queue.push_back(table_word(4, 32'h0000_0009, 8'h00, 16'h0000, 4'd8));
        word_queue.push_back(table_word(5, 32'h8000_0000, 8'h00, 16'h0001, 4'd8));
        word_queue.push_back(scan_word(1'b0, 8'h00));
        word_queue.push_back(scan_word(1'b0, 8'h00));
        word_queue.push_back(scan_word(1'b0, 8'h00));
        word_queue.push_back(make_word(ACT_TICK));
        word_queue.push_back(scan_word(1'b0, 8'hFF));
        word_queue.push_back(scan_word(1'b1, 8'h00));
        word_queue.push_back(scan_word(1'b0, 8'h00));
        word_queue.push_back(table_word(6, 32'h0000_0002, 8'h00, 16'h0000, 4'd0));
        word_queue.push_back(scan_word(1'b0, 8'h00));

        planned = 0;
        while (planned < RANDOM_WORDS)
        begin
            rows = $urandom_range(1, TABLE_SLOTS);
            for (int s = 0; s < rows; s++)
            begin
                cnt = (s == rows - 1) ? 4'(rows) : 4'($urandom_range(0, 15));
                if ($urandom_range(0, 9) == 0)
                    cnt = 4'($urandom_range(0, 15));
                word_queue.push_back(random_row(s, cnt));
                planned++;
            end
            repeat ($urandom_range(6, 20))
            begin
                if (planned < RANDOM_WORDS)
                begin
                    ticks = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    repeat (ticks)
                        word_queue.push_back(make_word(ACT_TICK));
                    planned += ticks;
                    case ($urandom_range(0, 19))
                        0:
                            word_queue.push_back(make_word(ACT_SPARE));
                        1, 2:
                        begin
                            word_queue.push_back(random_row($urandom_range(0, TABLE_SLOTS - 1),
                                                            4'($urandom_range(0, 15))));
                            planned++;
                        end
                        default:
                            ;
                    endcase
                    word_queue.push_back(scan_word($urandom_range(0, 14) == 0,
                        ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : 8'h00));
                    planned++;
                end
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (word_queue.size() != 0 || start || status_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result words: %0d ticks, %0d scans, %0d table writes, %0d spare.",
                 results_seen, ticks_taken, scans_taken, writes_taken, spares_taken);
        $display("Scans with a relay in alarm: %0d; scans where a relay reached done: %0d.",
                 alarm_scans, done_events);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/rtrs_pkg.sv
rtl/core/rtrs_ctrl.sv
rtl/core/rtrs_datapath.sv
rtl/core/remote_trip_relay_sequencer_top.sv
verif/remote_trip_relay_sequencer_top_test.sv
